// ===== design/gda_pkg.sv =====
package gda_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_CHK,
    ST_WALK,
    ST_DONE
  } state_e;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_INVALID  = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  localparam logic [3:0]  MONTH_JAN = 4'd1;
  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [3:0]  MONTH_DEC = 4'd12;
  localparam logic [13:0] YEAR_MAX  = 14'd16383;
  localparam logic [15:0] CYCLE_LEN = 16'd400;
  localparam logic [8:0]  CYCLE_END = 9'd399;

endpackage

// ===== design/gda_month_len.sv =====
module gda_month_len (
  input  logic [3:0] month_i,
  input  logic [8:0] rem400_i,
  output logic [4:0] len_o
);

  logic leap;

  // year mod 400: leap when a multiple of 4 but not 100, 200 or 300
  assign leap = (rem400_i[1:0] == 2'd0) && (rem400_i != 9'd100) &&
                (rem400_i != 9'd200) && (rem400_i != 9'd300);

  always_comb begin
    unique case (month_i)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len_o = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len_o = 5'd30;
      gda_pkg::MONTH_FEB:                          len_o = leap ? 5'd29 : 5'd28;
      default:                                     len_o = 5'd0;
    endcase
  end

endmodule

// ===== design/gda_sub_unit.sv =====
module gda_sub_unit (
  input  logic [15:0] a_i,
  input  logic [15:0] b_i,
  output logic [15:0] diff_o,
  output logic        ge_o
);

  logic [16:0] full;

  assign full   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = full[15:0];
  assign ge_o   = ~full[16];

endmodule

// ===== design/gregorian_date_add_days_top.sv =====
// Adds days_to_add_i days to a Gregorian date. A word is taken when start_i
// is high and busy_o is low; busy_o stays high until the result has been
// shown. The result appears on the result ports for exactly one cycle with
// done_o high and must be captured then, as it cannot be held off. One shared
// subtractor serves both phases: first it reduces the year mod 400 by
// subtracting 400 repeatedly, then the start date is checked, then the walk
// advances one month per cycle until the days are used up or the year
// overflows; then done_o is strobed.
// status_o: 0 ok, 1 invalid start date (result fields all 0), 2 year overflow
// (saturated at 31 Dec 16383).
module gregorian_date_add_days_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [3:0]  start_month_i,
  input  logic [4:0]  start_day_i,
  input  logic [13:0] start_year_i,
  input  logic [15:0] days_to_add_i,
  output logic        done_o,
  output logic [3:0]  result_month_o,
  output logic [4:0]  result_day_o,
  output logic [13:0] result_year_o,
  output logic [1:0]  status_o
);

  gda_pkg::state_e state_q, state_d;
  logic [3:0]  m_q, m_d;
  logic [4:0]  d_q, d_d;
  logic [13:0] y_q, y_d;
  logic [13:0] rem_q, rem_d;
  logic [15:0] left_q, left_d;
  logic [1:0]  status_q, status_d;

  logic [4:0]  len;
  logic [5:0]  step;
  logic [15:0] op_a, op_b, diff;
  logic        ge;
  logic [8:0]  rem_inc;

  gda_month_len u_len (
    .month_i  (m_q),
    .rem400_i (rem_q[8:0]),
    .len_o    (len)
  );

  gda_sub_unit u_sub (
    .a_i    (op_a),
    .b_i    (op_b),
    .diff_o (diff),
    .ge_o   (ge)
  );

  assign step    = {1'b0, len} - {1'b0, d_q} + 6'd1;
  assign rem_inc = (rem_q[8:0] == gda_pkg::CYCLE_END) ? 9'd0 : rem_q[8:0] + 9'd1;

  always_comb begin
    if (state_q == gda_pkg::ST_MOD) begin
      op_a = {2'b00, rem_q};
      op_b = gda_pkg::CYCLE_LEN;
    end else begin
      op_a = left_q;
      op_b = {10'd0, step};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gda_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q      <= m_d;
    d_q      <= d_d;
    y_q      <= y_d;
    rem_q    <= rem_d;
    left_q   <= left_d;
    status_q <= status_d;
  end

  always_comb begin
    state_d  = state_q;
    m_d      = m_q;
    d_d      = d_q;
    y_d      = y_q;
    rem_d    = rem_q;
    left_d   = left_q;
    status_d = status_q;
    unique case (state_q)
      gda_pkg::ST_IDLE: begin
        if (start_i) begin
          m_d      = start_month_i;
          d_d      = start_day_i;
          y_d      = start_year_i;
          rem_d    = start_year_i;
          left_d   = days_to_add_i;
          status_d = gda_pkg::STATUS_OK;
          state_d  = gda_pkg::ST_MOD;
        end
      end
      gda_pkg::ST_MOD: begin
        if (ge) begin
          rem_d = diff[13:0];
        end else begin
          state_d = gda_pkg::ST_CHK;
        end
      end
      gda_pkg::ST_CHK: begin
        if (m_q == 4'd0 || m_q > gda_pkg::MONTH_DEC || d_q == 5'd0 || d_q > len) begin
          m_d      = 4'd0;
          d_d      = 5'd0;
          y_d      = 14'd0;
          status_d = gda_pkg::STATUS_INVALID;
          state_d  = gda_pkg::ST_DONE;
        end else begin
          state_d = gda_pkg::ST_WALK;
        end
      end
      gda_pkg::ST_WALK: begin
        if (left_q == 16'd0) begin
          state_d = gda_pkg::ST_DONE;
        end else if (ge) begin
          left_d = diff;
          d_d    = 5'd1;
          if (m_q == gda_pkg::MONTH_DEC) begin
            if (y_q == gda_pkg::YEAR_MAX) begin
              d_d      = 5'd31;
              status_d = gda_pkg::STATUS_OVERFLOW;
              state_d  = gda_pkg::ST_DONE;
            end else begin
              m_d   = gda_pkg::MONTH_JAN;
              y_d   = y_q + 14'd1;
              rem_d = {5'd0, rem_inc};
            end
          end else begin
            m_d = m_q + 4'd1;
          end
        end else begin
          d_d     = d_q + left_q[4:0];
          left_d  = 16'd0;
          state_d = gda_pkg::ST_DONE;
        end
      end
      gda_pkg::ST_DONE: begin
        state_d = gda_pkg::ST_IDLE;
      end
      default: begin
        state_d = gda_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o         = (state_q != gda_pkg::ST_IDLE);
  assign done_o         = (state_q == gda_pkg::ST_DONE);
  assign result_month_o = m_q;
  assign result_day_o   = d_q;
  assign result_year_o  = y_q;
  assign status_o       = status_q;

`ifndef NO_ASSERTIONS
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("done without busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o)) else $error("start not taken");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gda_pkg::ST_WALK) |-> (rem_q < 14'd400)) else $error("year mod 400 out of range");

  a_walk_day: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gda_pkg::ST_WALK) |-> (d_q >= 5'd1 && d_q <= len)) else $error("day past month end");

  a_ok_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != gda_pkg::STATUS_INVALID) |->
      (result_month_o >= 4'd1 && result_month_o <= 4'd12 && result_day_o != 5'd0))
    else $error("bad result date");
`endif

endmodule
